### src/fat16_pkg.sv
// ----------------------------------------------------------------------------
// fat16_pkg
// Shared types and constants for the FAT16 root directory file search.
// ----------------------------------------------------------------------------
`default_nettype none

package fat16_pkg;

    // Directory entry layout
    localparam int unsigned ENTRY_BYTES   = 32;
    localparam int unsigned OFFSET_W      = $clog2(ENTRY_BYTES);

    localparam logic [OFFSET_W-1:0] OFF_NAME       = OFFSET_W'(0);
    localparam logic [OFFSET_W-1:0] OFF_ATTR       = OFFSET_W'(11);
    localparam logic [OFFSET_W-1:0] OFF_CLUSTER_LO = OFFSET_W'(26);
    localparam logic [OFFSET_W-1:0] OFF_CLUSTER_HI = OFFSET_W'(27);
    localparam logic [OFFSET_W-1:0] OFF_SIZE_0     = OFFSET_W'(28);
    localparam logic [OFFSET_W-1:0] OFF_SIZE_1     = OFFSET_W'(29);
    localparam logic [OFFSET_W-1:0] OFF_SIZE_2     = OFFSET_W'(30);
    localparam logic [OFFSET_W-1:0] OFF_SIZE_3     = OFFSET_W'(31);

    localparam logic [7:0]  DELETED_MARK = 8'hE5;
    localparam logic [7:0]  END_MARK     = 8'h00;
    localparam logic [4:0]  ATTR_MASK    = 5'h1F;
    localparam logic [31:0] CLUSTER_BIAS = 32'd2;
    localparam int unsigned SECTOR_SHIFT = 9;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_WANTED_INDEX = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLUSTER_SHIFT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_START   = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  WANTED_RESET = 8'd1;
    localparam logic [3:0]  SHIFT_RESET  = 4'd6;
    localparam logic [15:0] START_RESET  = 16'd0;

    // Stream widths
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = 64;
    localparam int unsigned M_TUSER_W = 1;

    typedef struct packed {
        logic        found;
        logic [31:0] file_byte_address;
        logic [31:0] file_size;
    } result_t;

endpackage

`default_nettype wire

### src/fat16_directory_file_search_top.sv
// ----------------------------------------------------------------------------
// fat16_directory_file_search_top
// Scans a FAT16 root directory byte stream for the n-th file entry and reports
// its byte address and size, or not-found at the end of the directory.
//
//   Channel  | Direction | Handshake            | Payload
//   ---------+-----------+----------------------+------------------------------
//   s_       | in        | s_tvalid / s_tready  | dir_byte, scan_start
//   m_       | out       | m_tvalid / m_tready  | found, byte address, size
//   cfg_     | in        | cfg_valid / cfg_ready| register index, data
//
// One directory byte is taken per cycle while s_tready is high and updates the
// scan state. A result from the last size byte or the end-of-directory byte
// goes to the output register, or to the skid register while m_ stalls; this
// two-entry buffer keeps s_tready high while one result waits on m_tready.
// Reset is synchronous, active low, and restores scan control state, valid
// flags and config; data registers are not reset. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module fat16_directory_file_search_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // s_tdata: [7:0] dir_byte
    input  wire logic [fat16_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: [0] scan_start
    input  wire logic [fat16_pkg::S_TUSER_W-1:0]  s_tuser,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // m_tdata: [31:0] file_byte_address, [63:32] file_size
    output logic [fat16_pkg::M_TDATA_W-1:0]       m_tdata,
    // m_tuser: [0] found
    output logic [fat16_pkg::M_TUSER_W-1:0]       m_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fat16_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fat16_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fat16_pkg::*;

    // Configuration
    logic [7:0]  wanted_reg;
    logic [3:0]  shift_reg;
    logic [15:0] start_sector_reg;

    // Scan state
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [7:0]          count_reg, count_next;
    logic                deleted_reg, deleted_next;
    logic                selected_reg, selected_next;
    logic                done_reg, done_next;
    logic [7:0]          clus_lo_reg, clus_lo_next;
    logic [31:0]         addr_reg, addr_next;
    logic [31:0]         size_reg, size_next;

    // Output buffer
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    logic                accept;
    logic [7:0]          dir_byte;
    logic                scan_start;
    logic [OFFSET_W-1:0] offset_cur;
    logic [7:0]          count_cur;
    logic                done_cur;
    logic [31:0]         cluster_addr;
    logic                res_valid;
    result_t             res;

    assign cfg_ready  = 1'b1;
    assign s_tready   = !skid_valid_reg;
    assign accept     = s_tvalid && s_tready;
    assign dir_byte   = s_tdata[7:0];
    assign scan_start = s_tuser[0];

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.found;
    assign m_tdata  = {out_reg.file_size, out_reg.file_byte_address};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_reg       <= WANTED_RESET;
            shift_reg        <= SHIFT_RESET;
            start_sector_reg <= START_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_WANTED_INDEX:  wanted_reg       <= cfg_data[7:0];
                CFG_CLUSTER_SHIFT: shift_reg        <= cfg_data[3:0];
                CFG_DATA_START:    start_sector_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sector of the entry's first cluster, scaled to bytes
    always_comb begin
        cluster_addr = ({16'd0, dir_byte, clus_lo_reg} - CLUSTER_BIAS) << shift_reg;
        cluster_addr = (cluster_addr + {16'd0, start_sector_reg}) << SECTOR_SHIFT;
    end

    always_comb begin
        offset_next   = offset_reg;
        count_next    = count_reg;
        deleted_next  = deleted_reg;
        selected_next = selected_reg;
        done_next     = done_reg;
        clus_lo_next  = clus_lo_reg;
        addr_next     = addr_reg;
        size_next     = size_reg;
        res_valid     = 1'b0;
        res           = '0;

        offset_cur = scan_start ? OFF_NAME : offset_reg;
        count_cur  = scan_start ? 8'd1 : count_reg;
        done_cur   = scan_start ? 1'b0 : done_reg;

        if (accept) begin
            offset_next = offset_cur;
            count_next  = count_cur;
            done_next   = done_cur;
            if (!done_cur) begin
                offset_next = offset_cur + OFFSET_W'(1);
                if (offset_cur == OFF_NAME) begin
                    if (dir_byte == END_MARK) begin
                        done_next = 1'b1;
                        res_valid = 1'b1;
                    end else begin
                        deleted_next  = (dir_byte == DELETED_MARK);
                        selected_next = 1'b0;
                    end
                end else if (offset_cur == OFF_ATTR) begin
                    if (!deleted_reg && ((dir_byte[4:0] & ATTR_MASK) == 5'd0)) begin
                        if (count_cur == wanted_reg) begin
                            selected_next = 1'b1;
                        end else begin
                            count_next = count_cur + 8'd1;
                        end
                    end
                end else if (offset_cur == OFF_CLUSTER_LO) begin
                    clus_lo_next = dir_byte;
                end else if (offset_cur == OFF_CLUSTER_HI) begin
                    addr_next = cluster_addr;
                end else if (offset_cur == OFF_SIZE_0) begin
                    size_next = {24'd0, dir_byte};
                end else if (offset_cur == OFF_SIZE_1) begin
                    size_next[15:8] = dir_byte;
                end else if (offset_cur == OFF_SIZE_2) begin
                    size_next[23:16] = dir_byte;
                end else if (offset_cur == OFF_SIZE_3) begin
                    size_next[31:24] = dir_byte;
                    if (selected_reg) begin
                        done_next               = 1'b1;
                        res_valid               = 1'b1;
                        res.found               = 1'b1;
                        res.file_byte_address   = addr_reg;
                        res.file_size           = {dir_byte, size_reg[23:0]};
                    end
                end
            end
        end
    end

    // Output register plus skid register; skid fills only while m_ stalls
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end else if (!out_valid_reg) begin
            out_valid_next = res_valid;
            out_next       = res;
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg     <= OFF_NAME;
            count_reg      <= 8'd1;
            deleted_reg    <= 1'b0;
            selected_reg   <= 1'b0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            offset_reg     <= offset_next;
            count_reg      <= count_next;
            deleted_reg    <= deleted_next;
            selected_reg   <= selected_next;
            done_reg       <= done_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        clus_lo_reg <= clus_lo_next;
        addr_reg    <= addr_next;
        size_reg    <= size_next;
        out_reg     <= out_next;
        skid_reg    <= skid_next;
    end

    // Skid register holds data only behind a valid output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register valid while output register empty");

    // A not-found result carries zero address and size
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.found) |->
            (out_reg.file_byte_address == 32'd0 && out_reg.file_size == 32'd0))
        else $error("not-found result with nonzero payload");

    // Every result ends the scan until the next scan start
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> done_reg)
        else $error("scan not marked done after a result");

    // A found result needs the entry to have been selected
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.found) |-> selected_reg)
        else $error("found result without a selected entry");

endmodule

`default_nettype wire
